// File: design/ssh_pkg.sv
// Shared types, constants and helpers for the state-space horizon predictor.
// No dependencies; every other design file imports this package.
package ssh_pkg;

  localparam int DATA_W    = 32;
  localparam int PROD_W    = 48;
  localparam int ACC_W     = 52;
  localparam int COST_W    = 64;
  localparam int STEP_W    = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IW    = 1;
  localparam int MAX_LANES = 4;
  localparam int MAX_OUT   = 2;
  localparam int MAX_IN    = 2;
  localparam int BANK_DEPTH = 14;
  localparam int BANK_AW   = 4;

  localparam int DEF_STATE_SIZE  = 4;
  localparam int DEF_INPUT_SIZE  = 2;
  localparam int DEF_OUTPUT_SIZE = 2;
  localparam int DEF_HORIZON_MAX = 64;

  localparam logic [CFG_W-1:0] NP_RESET = 7'd10;
  localparam logic [CFG_W-1:0] NC_RESET = 7'd5;

  localparam logic [CFG_IW-1:0] REG_PRED_HORIZON = 1'd0;
  localparam logic [CFG_IW-1:0] REG_CTRL_HORIZON = 1'd1;

  localparam logic [1:0] CMD_COEF  = 2'd0;
  localparam logic [1:0] CMD_STATE = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic [2:0] MAT_AD = 3'd0;
  localparam logic [2:0] MAT_BD = 3'd1;
  localparam logic [2:0] MAT_C  = 3'd2;
  localparam logic [2:0] MAT_Q  = 3'd3;
  localparam logic [2:0] MAT_R  = 3'd4;

  localparam logic [BANK_AW-1:0] OFS_AD = 4'd0;
  localparam logic [BANK_AW-1:0] OFS_BD = 4'd4;
  localparam logic [BANK_AW-1:0] OFS_C  = 4'd6;
  localparam logic [BANK_AW-1:0] OFS_Q  = 4'd10;
  localparam logic [BANK_AW-1:0] OFS_R  = 4'd12;

  typedef struct packed {
    logic                     en;
    logic [1:0]               lane;
    logic [BANK_AW-1:0]       addr;
    logic signed [DATA_W-1:0] data;
  } lane_wr_t;

  typedef struct packed {
    logic                     issue;
    logic                     term;
    logic                     hold;
    logic                     clr;
    logic [BANK_AW-1:0]       addr;
    logic signed [DATA_W-1:0] b;
  } lane_ctl_t;

  typedef struct packed {
    logic                 clr;
    logic                 add;
    logic [MAX_LANES-1:0] mask;
  } merge_ctl_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if ((&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1]))
      return v[DATA_W-1:0];
    else if (v[ACC_W-1])
      return 32'sh8000_0000;
    else
      return 32'sh7fff_ffff;
  endfunction

endpackage

// File: design/ssh_if.sv
// Valid/ready channel interfaces for the input and result beats.
// Depends on ssh_pkg for field widths.
interface ssh_in_if import ssh_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [2:0]               matrix_select;
  logic [1:0]               row_index;
  logic [1:0]               col_index;
  logic signed [DATA_W-1:0] load_value;
  logic signed [DATA_W-1:0] drive_0;
  logic signed [DATA_W-1:0] drive_1;
  logic signed [DATA_W-1:0] target_0;
  logic signed [DATA_W-1:0] target_1;
  modport source (output valid, command, matrix_select, row_index, col_index, load_value,
                  drive_0, drive_1, target_0, target_1, input ready);
  modport sink (input valid, command, matrix_select, row_index, col_index, load_value,
                drive_0, drive_1, target_0, target_1, output ready);
endinterface

interface ssh_out_if import ssh_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] predicted_0;
  logic signed [DATA_W-1:0] predicted_1;
  logic signed [COST_W-1:0] running_cost;
  logic                     last_step;
  modport source (output valid, predicted_0, predicted_1, running_cost, last_step,
                  input ready);
  modport sink (input valid, predicted_0, predicted_1, running_cost, last_step,
                output ready);
endinterface

// File: design/ssh_lane.sv
// One multiply-accumulate lane with its own coefficient bank (one matrix row).
// Depends on ssh_pkg.
module ssh_lane import ssh_pkg::*; #(
  parameter int LANE = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lane_wr_t                 wr,
  input  lane_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] lv,
  output logic signed [ACC_W-1:0]  acc,
  output logic signed [DATA_W-1:0] acc_sat
);

  logic signed [DATA_W-1:0] bank_r [BANK_DEPTH];
  logic signed [DATA_W-1:0] rd_r;
  logic signed [DATA_W-1:0] b_r;
  logic signed [DATA_W-1:0] w_r;
  logic                     t1_r;
  logic                     v1_r;
  logic                     v2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [63:0]       full;

  assign mul_a   = t1_r ? lv : rd_r;
  assign mul_b   = t1_r ? w_r : b_r;
  assign full    = mul_a * mul_b;
  assign acc     = acc_r;
  assign acc_sat = sat32(acc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.lane == 2'(LANE)) begin
      bank_r[wr.addr] <= wr.data;
    end
    rd_r   <= bank_r[ctl.addr];
    b_r    <= ctl.b;
    t1_r   <= ctl.term;
    prod_r <= PROD_W'(full >>> 16);
    if (ctl.hold) begin
      w_r <= acc_sat;
    end
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

endmodule

// File: design/ssh_merge.sv
// Merge stage: sums lane terms and adds them to the saturating running cost.
// Depends on ssh_pkg.
module ssh_merge import ssh_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  merge_ctl_t               ctl,
  input  logic signed [ACC_W-1:0]  lane_acc [MAX_LANES],
  output logic signed [COST_W-1:0] cost
);

  logic signed [COST_W-1:0] cost_r;
  logic signed [COST_W-1:0] cost_nxt;
  logic signed [COST_W-1:0] term_sum;
  logic signed [COST_W:0]   wide;

  always_comb begin
    term_sum = '0;
    for (int i = 0; i < MAX_LANES; i++) begin
      if (ctl.mask[i]) term_sum = term_sum + COST_W'(lane_acc[i]);
    end
    wide = (COST_W+1)'(cost_r) + (COST_W+1)'(term_sum);
    if (wide[COST_W] != wide[COST_W-1])
      cost_nxt = wide[COST_W] ? {1'b1, {(COST_W-1){1'b0}}} : {1'b0, {(COST_W-1){1'b1}}};
    else
      cost_nxt = wide[COST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r <= '0;
    end else if (ctl.clr) begin
      cost_r <= '0;
    end else if (ctl.add) begin
      cost_r <= cost_nxt;
    end
  end

  assign cost = cost_r;

endmodule

// File: design/state_space_horizon_predictor.sv
// Load beats are taken while idle. A step runs phases on the lane MAC pipelines
// (memory read, multiply, add); past the control horizon the two input-penalty phases
// are skipped. Input is not ready again until the step's result is written to the
// output register, so a new beat is taken only after the previous step completes.
// A result still waiting in the output register holds the step. Synchronous active-low
// reset clears plant state, held drive, step count, cost, horizons (10, 5); banks undefined.
module state_space_horizon_predictor import ssh_pkg::*; #(
  parameter int STATE_SIZE  = DEF_STATE_SIZE,
  parameter int INPUT_SIZE  = DEF_INPUT_SIZE,
  parameter int OUTPUT_SIZE = DEF_OUTPUT_SIZE,
  parameter int HORIZON_MAX = DEF_HORIZON_MAX
) (
  input  logic              clk,
  input  logic              rst_n,
  ssh_in_if.sink            in_ch,
  ssh_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int LANES = (STATE_SIZE > OUTPUT_SIZE) ?
                         ((STATE_SIZE > INPUT_SIZE) ? STATE_SIZE : INPUT_SIZE) :
                         ((OUTPUT_SIZE > INPUT_SIZE) ? OUTPUT_SIZE : INPUT_SIZE);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  localparam logic [2:0] P_Y  = 3'd0;
  localparam logic [2:0] P_QE = 3'd1;
  localparam logic [2:0] P_QT = 3'd2;
  localparam logic [2:0] P_RU = 3'd3;
  localparam logic [2:0] P_RT = 3'd4;
  localparam logic [2:0] P_X  = 3'd5;

  logic [1:0]               state_r, state_nxt;
  logic [2:0]               phase_r, phase_nxt;
  logic [2:0]               idx_r, idx_nxt;
  logic                     wait_r, wait_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic                     inctl_r, inctl_nxt;
  logic [CFG_W-1:0]         np_cfg_r, nc_cfg_r;
  logic signed [DATA_W-1:0] x_r [MAX_LANES];
  logic signed [DATA_W-1:0] x_nxt [MAX_LANES];
  logic signed [DATA_W-1:0] u_r [MAX_IN];
  logic signed [DATA_W-1:0] u_nxt [MAX_IN];
  logic signed [DATA_W-1:0] y_r [MAX_OUT];
  logic signed [DATA_W-1:0] y_nxt [MAX_OUT];
  logic signed [DATA_W-1:0] e_r [MAX_OUT];
  logic signed [DATA_W-1:0] e_nxt [MAX_OUT];
  logic signed [DATA_W-1:0] tgt_r [MAX_OUT];
  logic signed [DATA_W-1:0] tgt_nxt [MAX_OUT];
  logic signed [DATA_W-1:0] drv [MAX_IN];
  logic signed [DATA_W-1:0] tgt_in [MAX_OUT];

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_p0_r, out_p0_nxt;
  logic signed [DATA_W-1:0] out_p1_r, out_p1_nxt;
  logic signed [COST_W-1:0] out_cost_r, out_cost_nxt;
  logic                     out_last_r, out_last_nxt;

  logic [CFG_W-1:0]         np, nc;
  logic [STEP_W-1:0]        sc;
  logic                     accept;
  logic [2:0]               plen;
  lane_wr_t                 wr;
  lane_ctl_t                lctl;
  merge_ctl_t               mctl;
  logic signed [DATA_W-1:0] lv [MAX_LANES];
  logic signed [ACC_W-1:0]  lane_acc [MAX_LANES];
  logic signed [DATA_W-1:0] lane_sat [MAX_LANES];
  logic signed [COST_W-1:0] cost;

  assign drv[0]    = in_ch.drive_0;
  assign drv[1]    = (INPUT_SIZE > 1) ? in_ch.drive_1 : '0;
  assign tgt_in[0] = in_ch.target_0;
  assign tgt_in[1] = (OUTPUT_SIZE > 1) ? in_ch.target_1 : '0;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    np = np_cfg_r;
    if (np == '0) np = 7'd1;
    if (np > 7'(HORIZON_MAX)) np = 7'(HORIZON_MAX);
    nc = nc_cfg_r;
    if (nc == '0) nc = 7'd1;
    if (nc > np) nc = np;
  end

  always_comb begin
    unique case (phase_r)
      P_Y:     plen = 3'(STATE_SIZE);
      P_QE:    plen = 3'(OUTPUT_SIZE);
      P_RU:    plen = 3'(INPUT_SIZE);
      P_X:     plen = 3'(STATE_SIZE + INPUT_SIZE);
      default: plen = 3'd1;
    endcase
  end

  always_comb begin
    wr      = '0;
    wr.lane = in_ch.row_index;
    wr.data = in_ch.load_value;
    if (accept && in_ch.command == CMD_COEF) begin
      unique case (in_ch.matrix_select)
        MAT_AD: begin
          wr.en   = (32'(in_ch.row_index) < STATE_SIZE) && (32'(in_ch.col_index) < STATE_SIZE);
          wr.addr = OFS_AD + 4'(in_ch.col_index);
        end
        MAT_BD: begin
          wr.en   = (32'(in_ch.row_index) < STATE_SIZE) && (32'(in_ch.col_index) < INPUT_SIZE);
          wr.addr = OFS_BD + 4'(in_ch.col_index);
        end
        MAT_C: begin
          wr.en   = (32'(in_ch.row_index) < OUTPUT_SIZE) && (32'(in_ch.col_index) < STATE_SIZE);
          wr.addr = OFS_C + 4'(in_ch.col_index);
        end
        MAT_Q: begin
          wr.en   = (32'(in_ch.row_index) < OUTPUT_SIZE) && (32'(in_ch.col_index) < OUTPUT_SIZE);
          wr.addr = OFS_Q + 4'(in_ch.col_index);
        end
        MAT_R: begin
          wr.en   = (32'(in_ch.row_index) < INPUT_SIZE) && (32'(in_ch.col_index) < INPUT_SIZE);
          wr.addr = OFS_R + 4'(in_ch.col_index);
        end
        default: wr.en = 1'b0;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_LANES; i++) begin
      lv[i] = '0;
      if (phase_r == P_QT && i < OUTPUT_SIZE && i < MAX_OUT) lv[i] = e_r[i % MAX_OUT];
      if (phase_r == P_RT && i < INPUT_SIZE && i < MAX_IN) lv[i] = u_r[i % MAX_IN];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    wait_nxt      = wait_r;
    step_nxt      = step_r;
    inctl_nxt     = inctl_r;
    x_nxt         = x_r;
    u_nxt         = u_r;
    y_nxt         = y_r;
    e_nxt         = e_r;
    tgt_nxt       = tgt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_p0_nxt    = out_p0_r;
    out_p1_nxt    = out_p1_r;
    out_cost_nxt  = out_cost_r;
    out_last_nxt  = out_last_r;
    lctl          = '0;
    mctl          = '0;
    sc            = (step_r >= np) ? '0 : step_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept && in_ch.command == CMD_STATE) begin
          for (int k = 0; k < STATE_SIZE; k++) begin
            if (32'(in_ch.row_index) == k) x_nxt[k] = in_ch.load_value;
          end
          step_nxt = '0;
          mctl.clr = 1'b1;
        end else if (accept && in_ch.command == CMD_STEP) begin
          if (step_r >= np) mctl.clr = 1'b1;
          step_nxt  = sc;
          inctl_nxt = (sc < nc);
          if (sc < nc) u_nxt = drv;
          tgt_nxt   = tgt_in;
          lctl.clr  = 1'b1;
          phase_nxt = P_Y;
          idx_nxt   = '0;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        lctl.issue = 1'b1;
        lctl.term  = (phase_r == P_QT) || (phase_r == P_RT);
        for (int k = 0; k < MAX_LANES; k++) begin
          if (phase_r == P_Y && 32'(idx_r) == k) begin
            lctl.b = x_r[k];
            lctl.addr = OFS_C + 4'(idx_r);
          end
          if (phase_r == P_X && 32'(idx_r) == k && k < STATE_SIZE) begin
            lctl.b = x_r[k];
            lctl.addr = OFS_AD + 4'(idx_r);
          end
        end
        for (int k = 0; k < MAX_OUT; k++) begin
          if (phase_r == P_QE && 32'(idx_r) == k) begin
            lctl.b = e_r[k];
            lctl.addr = OFS_Q + 4'(idx_r);
          end
        end
        for (int k = 0; k < MAX_IN; k++) begin
          if (phase_r == P_RU && 32'(idx_r) == k) begin
            lctl.b = u_r[k];
            lctl.addr = OFS_R + 4'(idx_r);
          end
          if (phase_r == P_X && 32'(idx_r) == STATE_SIZE + k) begin
            lctl.b = u_r[k];
            lctl.addr = OFS_BD + 4'(k);
          end
        end
        idx_nxt = idx_r + 3'd1;
        if (idx_r == plen - 3'd1) begin
          state_nxt = S_WAIT;
          wait_nxt  = 1'b0;
        end
      end
      S_WAIT: begin
        wait_nxt = 1'b1;
        if (wait_r) state_nxt = S_FIN;
      end
      default: begin
        idx_nxt   = '0;
        state_nxt = S_ISSUE;
        lctl.clr  = 1'b1;
        unique case (phase_r)
          P_Y: begin
            for (int i = 0; i < MAX_OUT; i++) begin
              y_nxt[i] = (i < OUTPUT_SIZE) ? lane_sat[i] : '0;
              e_nxt[i] = sat32(ACC_W'(y_nxt[i]) - ACC_W'(tgt_r[i]));
            end
            phase_nxt = P_QE;
          end
          P_QE: begin
            lctl.hold = 1'b1;
            phase_nxt = P_QT;
          end
          P_QT: begin
            mctl.add = 1'b1;
            for (int i = 0; i < MAX_LANES; i++) mctl.mask[i] = (i < OUTPUT_SIZE);
            phase_nxt = inctl_r ? P_RU : P_X;
          end
          P_RU: begin
            lctl.hold = 1'b1;
            phase_nxt = P_RT;
          end
          P_RT: begin
            mctl.add = 1'b1;
            for (int i = 0; i < MAX_LANES; i++) mctl.mask[i] = (i < INPUT_SIZE);
            phase_nxt = P_X;
          end
          default: begin
            if (!out_valid_r || out_ch.ready) begin
              for (int i = 0; i < STATE_SIZE; i++) x_nxt[i] = lane_sat[i];
              step_nxt      = step_r + 7'd1;
              out_valid_nxt = 1'b1;
              out_p0_nxt    = y_r[0];
              out_p1_nxt    = y_r[1];
              out_cost_nxt  = cost;
              out_last_nxt  = (step_r + 7'd1 == np);
              state_nxt     = S_IDLE;
            end else begin
              lctl.clr  = 1'b0;
              state_nxt = S_FIN;
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= P_Y;
      idx_r       <= '0;
      wait_r      <= 1'b0;
      step_r      <= '0;
      inctl_r     <= 1'b0;
      out_valid_r <= 1'b0;
      np_cfg_r    <= NP_RESET;
      nc_cfg_r    <= NC_RESET;
      for (int i = 0; i < MAX_LANES; i++) x_r[i] <= '0;
      for (int i = 0; i < MAX_IN; i++) u_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      wait_r      <= wait_nxt;
      step_r      <= step_nxt;
      inctl_r     <= inctl_nxt;
      out_valid_r <= out_valid_nxt;
      x_r         <= x_nxt;
      u_r         <= u_nxt;
      if (cfg_we && cfg_index == REG_PRED_HORIZON) np_cfg_r <= cfg_wdata;
      if (cfg_we && cfg_index == REG_CTRL_HORIZON) nc_cfg_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    y_r        <= y_nxt;
    e_r        <= e_nxt;
    tgt_r      <= tgt_nxt;
    out_p0_r   <= out_p0_nxt;
    out_p1_r   <= out_p1_nxt;
    out_cost_r <= out_cost_nxt;
    out_last_r <= out_last_nxt;
  end

  for (genvar g = 0; g < MAX_LANES; g++) begin : g_lane
    if (g < LANES) begin : g_on
      ssh_lane #(.LANE(g)) u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .ctl     (lctl),
        .lv      (lv[g]),
        .acc     (lane_acc[g]),
        .acc_sat (lane_sat[g])
      );
    end else begin : g_off
      assign lane_acc[g] = '0;
      assign lane_sat[g] = '0;
    end
  end

  ssh_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mctl),
    .lane_acc (lane_acc),
    .cost     (cost)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.predicted_0  = out_p0_r;
  assign out_ch.predicted_1  = out_p1_r;
  assign out_ch.running_cost = out_cost_r;
  assign out_ch.last_step    = out_last_r;

endmodule

// File: design/ssh_checker.sv
// Port-level checks for the state-space horizon predictor, bound to the top level.
// Depends on ssh_pkg for command codes and widths.
module ssh_checker import ssh_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [1:0]               in_command,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [COST_W-1:0] out_cost
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_cost_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_cost))
    else $error("running cost changed while stalled");

  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_STEP |=> !in_ready)
    else $error("input taken during a step");

  a_no_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared right after an accepted beat");

endmodule

bind state_space_horizon_predictor ssh_checker u_ssh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_command (in_ch.command),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_cost   (out_ch.running_cost)
);
